// ----- sv/grmv_pkg.sv -----
// Shared types and constants of the grid running mean and variance core.
package grmv_pkg;

	localparam int GRID_SIDE_MAX = 32;
	localparam int DEPTH         = GRID_SIDE_MAX * GRID_SIDE_MAX;
	localparam int IDX_BITS      = $clog2(DEPTH);
	localparam int SMP_BITS      = 13;
	localparam int MAX_SAMPLES   = 8191;
	localparam int VALUE_BITS    = 24;
	localparam int M2_BITS       = 48;
	localparam int SQ_BITS       = 64;
	localparam int ROW_BITS      = 2 * VALUE_BITS + 2 * M2_BITS;

	// Register indexes of the configuration port
	localparam logic REG_GRID_SIDE    = 1'b0;
	localparam logic REG_ENERGY_SCALE = 1'b1;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] u_value;
		logic signed [VALUE_BITS-1:0] v_value;
	} in_word_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]          point_index;
		logic [SMP_BITS-1:0]          sample_index;
		logic signed [VALUE_BITS-1:0] mean_u;
		logic [M2_BITS-1:0]           spread_u;
		logic signed [VALUE_BITS-1:0] mean_v;
		logic [M2_BITS-1:0]           spread_v;
		logic                         last_point;
		logic [M2_BITS-1:0]           energy;
		logic                         count_full;
	} out_word_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic [IDX_BITS-1:0]          idx;
		logic [SMP_BITS-1:0]          sidx;
		logic signed [VALUE_BITS-1:0] u;
		logic signed [VALUE_BITS-1:0] v;
		logic                         first;
		logic                         last;
		logic                         full;
	} item_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic       not_empty;
		logic       is_full;
		logic [1:0] count;
	} queue_status_t;

endpackage

// ----- sv/grmv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module grmv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read one entry each cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/grmv_front.sv -----
// Front end: counts points and samples and classifies each accepted word.
module grmv_front import grmv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_word_t word,
	input  logic [5:0] grid_side,
	output item_t    item
);

	logic [IDX_BITS-1:0] point_q;
	logic [SMP_BITS-1:0] sample_q;
	logic [5:0]          side;
	logic [11:0]         npts;
	logic                last;
	logic                full;

	// Clamp grid side and find the end of the sample
	always_comb begin
		side = grid_side;
		if (grid_side == 6'd0) begin
			side = 6'd1;
		end else if (grid_side > 6'(GRID_SIDE_MAX)) begin
			side = 6'(GRID_SIDE_MAX);
		end
		npts = 12'(side) * 12'(side);
		last = (12'(point_q) + 12'd1) >= npts;
		full = sample_q >= SMP_BITS'(MAX_SAMPLES - 1);
	end

	assign item.idx   = point_q;
	assign item.sidx  = sample_q;
	assign item.u     = word.u_value;
	assign item.v     = word.v_value;
	assign item.first = (sample_q == '0);
	assign item.last  = last;
	assign item.full  = full;

	// Advance counters on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q  <= '0;
			sample_q <= '0;
		end else if (push) begin
			if (last) begin
				point_q <= '0;
				if (!full) begin
					sample_q <= sample_q + 1'b1;
				end
			end else begin
				point_q <= point_q + 1'b1;
			end
		end
	end

endmodule

// ----- sv/grmv_queue.sv -----
// Two-entry queue between front and back.
module grmv_queue import grmv_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  item_t         push_item,
	input  logic          pop,
	output item_t         head,
	output queue_status_t status
);

	item_t      slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign head             = slot_q[rptr_q];
	assign status.count     = count_q;
	assign status.not_empty = (count_q != 2'd0);
	assign status.is_full   = (count_q == 2'd2);

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- sv/grmv_back.sv -----
// Back end: Welford update with serial dividers, energy scaling, output register.
module grmv_back import grmv_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  item_t         head,
	input  queue_status_t qstat,
	input  logic [31:0]   energy_scale,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output out_word_t     out_word,
	output logic          busy
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_READ = 9'b000000010,
		ST_DIV  = 9'b000000100,
		ST_NEWM = 9'b000001000,
		ST_PROD = 9'b000010000,
		ST_ACC  = 9'b000100000,
		ST_E1   = 9'b001000000,
		ST_E2   = 9'b010000000,
		ST_E3   = 9'b100000000
	} state_t;

	localparam int DW = VALUE_BITS + 1;

	state_t                   state_q;
	item_t                    item_q;
	logic [4:0]               cnt_q;
	logic [SMP_BITS:0]        n_q;
	logic [ROW_BITS-1:0]      rdata;
	logic [ROW_BITS-1:0]      wdata;
	logic                     we;
	logic signed [VALUE_BITS-1:0] mu_q, mv_q, nmu_q, nmv_q;
	logic [M2_BITS-1:0]       m2u_q, m2v_q, su_q, sv_q;
	logic signed [DW-1:0]     du_q, dv_q, eu_q, ev_q;
	logic [DW-1:0]            dvu_q, dvv_q, qu_q, qv_q;
	logic [SMP_BITS:0]        ru_q, rv_q;
	logic [2*DW-1:0]          pu_q, pv_q;
	logic [2*VALUE_BITS-1:0]  uu_q, vv_q;
	logic [SQ_BITS-1:0]       sq_q;
	logic [63:0]              plo_q, phi_q;
	logic                     out_valid_q;
	out_word_t                out_q;

	// Row holds both means and both spreads
	grmv_ram #(.WIDTH(ROW_BITS), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(item_q.idx),
		.wdata(wdata),
		.raddr(head.idx),
		.rdata(rdata)
	);

	assign pop       = (state_q == ST_IDLE) && qstat.not_empty && !out_valid_q;
	assign busy      = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	// Write back once the updated row sits in the output register
	assign we        = (state_q == ST_E1);
	assign wdata     = {out_q.mean_u, out_q.mean_v, out_q.spread_u, out_q.spread_v};

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
		return x[DW-1] ? DW'(-x) : DW'(x);
	endfunction

	// One restoring divide step
	function automatic logic [SMP_BITS+1:0] dstep(input logic [SMP_BITS:0] r,
			input logic b, input logic [SMP_BITS:0] n);
		logic [SMP_BITS+1:0] t;
		t = {r, b};
		if (t >= {1'b0, n}) begin
			return {t[SMP_BITS:0] - n, 1'b1};
		end
		return {t[SMP_BITS:0], 1'b0};
	endfunction

	function automatic logic [M2_BITS-1:0] sat48(input logic [M2_BITS-1:0] a,
			input logic [2*DW-1:0] b);
		logic [2*DW:0] s;
		s = (2*DW+1)'(a) + (2*DW+1)'(b);
		if (s[2*DW:M2_BITS] != '0) begin
			return '1;
		end
		return s[M2_BITS-1:0];
	endfunction

	function automatic logic [SQ_BITS-1:0] sat64(input logic [SQ_BITS-1:0] a,
			input logic [2*VALUE_BITS-1:0] b);
		logic [SQ_BITS:0] s;
		s = (SQ_BITS+1)'(a) + (SQ_BITS+1)'(b);
		return s[SQ_BITS] ? '1 : s[SQ_BITS-1:0];
	endfunction

	logic [SMP_BITS+1:0] stu, stv;
	assign stu = dstep(ru_q, dvu_q[DW-1], n_q);
	assign stv = dstep(rv_q, dvv_q[DW-1], n_q);

	logic signed [DW:0] qsu, qsv;
	assign qsu = du_q[DW-1] ? -(DW+1)'(qu_q) : (DW+1)'(qu_q);
	assign qsv = dv_q[DW-1] ? -(DW+1)'(qv_q) : (DW+1)'(qv_q);

	logic [32:0] mid;
	logic [32:0] upper;
	assign mid   = 33'(plo_q[63:32]) + 33'(phi_q[31:0]);
	assign upper = 33'(phi_q[63:32]) + 33'(mid[32]);

	// Sequence one item through read, divide, update and scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			sq_q        <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(DW - 1)) begin
						state_q <= ST_NEWM;
					end
				end
				ST_NEWM: state_q <= ST_PROD;
				ST_PROD: begin
					state_q <= ST_ACC;
					sq_q    <= sat64(sq_q, uu_q);
				end
				ST_ACC: begin
					state_q <= ST_E1;
					sq_q    <= sat64(sq_q, vv_q);
				end
				ST_E1: state_q <= ST_E2;
				ST_E2: state_q <= ST_E3;
				ST_E3: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
					if (item_q.last) begin
						sq_q <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= head;
				n_q    <= (SMP_BITS+1)'(head.sidx) + 1'b1;
			end
			ST_READ: begin
				mu_q  <= rdata[ROW_BITS-1 -: VALUE_BITS];
				mv_q  <= rdata[ROW_BITS-VALUE_BITS-1 -: VALUE_BITS];
				m2u_q <= rdata[2*M2_BITS-1 -: M2_BITS];
				m2v_q <= rdata[M2_BITS-1:0];
				du_q  <= DW'(item_q.u) - DW'($signed(rdata[ROW_BITS-1 -: VALUE_BITS]));
				dv_q  <= DW'(item_q.v) -
					DW'($signed(rdata[ROW_BITS-VALUE_BITS-1 -: VALUE_BITS]));
				dvu_q <= mag(DW'(item_q.u) - DW'($signed(rdata[ROW_BITS-1 -: VALUE_BITS])));
				dvv_q <= mag(DW'(item_q.v) -
					DW'($signed(rdata[ROW_BITS-VALUE_BITS-1 -: VALUE_BITS])));
				ru_q  <= '0;
				rv_q  <= '0;
				uu_q  <= VALUE_BITS'(mag(DW'(item_q.u))) * VALUE_BITS'(mag(DW'(item_q.u)));
				vv_q  <= VALUE_BITS'(mag(DW'(item_q.v))) * VALUE_BITS'(mag(DW'(item_q.v)));
			end
			ST_DIV: begin
				ru_q  <= stu[SMP_BITS+1:1];
				rv_q  <= stv[SMP_BITS+1:1];
				qu_q  <= {qu_q[DW-2:0], stu[0]};
				qv_q  <= {qv_q[DW-2:0], stv[0]};
				dvu_q <= {dvu_q[DW-2:0], 1'b0};
				dvv_q <= {dvv_q[DW-2:0], 1'b0};
			end
			ST_NEWM: begin
				nmu_q <= VALUE_BITS'((DW+1)'(mu_q) + qsu);
				nmv_q <= VALUE_BITS'((DW+1)'(mv_q) + qsv);
				eu_q  <= DW'((DW+1)'(item_q.u) - (DW+1)'(mu_q) - qsu);
				ev_q  <= DW'((DW+1)'(item_q.v) - (DW+1)'(mv_q) - qsv);
			end
			ST_PROD: begin
				pu_q <= mag(du_q) * mag(eu_q);
				pv_q <= mag(dv_q) * mag(ev_q);
				su_q <= sat48(m2u_q, '0);
				sv_q <= sat48(m2v_q, '0);
			end
			ST_ACC: begin
				out_q.point_index  <= item_q.idx;
				out_q.sample_index <= item_q.sidx;
				out_q.last_point   <= item_q.last;
				out_q.count_full   <= item_q.full;
				if (item_q.first) begin
					out_q.mean_u   <= item_q.u;
					out_q.mean_v   <= item_q.v;
					out_q.spread_u <= '0;
					out_q.spread_v <= '0;
				end else begin
					out_q.mean_u   <= nmu_q;
					out_q.mean_v   <= nmv_q;
					out_q.spread_u <= sat48(su_q, pu_q);
					out_q.spread_v <= sat48(sv_q, pv_q);
				end
			end
			ST_E1: plo_q <= 64'(sq_q[31:0]) * 64'(energy_scale);
			ST_E2: phi_q <= 64'(sq_q[63:32]) * 64'(energy_scale);
			ST_E3: begin
				if (!item_q.last) begin
					out_q.energy <= '0;
				end else if (upper >= 33'h100000) begin
					out_q.energy <= '1;
				end else begin
					out_q.energy <= {upper[19:0], mid[31:4]};
				end
			end
			default: item_q <= item_q;
		endcase
	end

endmodule

// ----- sv/grid_running_mean_variance_core.sv -----
// Top level of the grid running mean and variance core.
//
//  channel | direction | handshake           | word
//  in      | input     | in_valid / in_stall | in_word_t (u_value, v_value)
//  out     | output    | out_valid/out_stall | out_word_t (one per input word)
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// Each word holds the back end through the pop, a read, the bit-serial
// dividers for the two means, mean update, products, output update, then
// write-back with two 32x32 energy multiplies and a final combine. The next
// pop waits until the result is taken. A two-entry queue lets the front
// accept words while the back works; in_stall rises when it is full. Reset
// clears counters, the square sum and handshakes; the point store is not
// cleared.
module grid_running_mean_variance_core import grmv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [5:0]    grid_side_q;
	logic [31:0]   energy_scale_q;
	logic          push;
	logic          pop;
	logic          busy;
	item_t         front_item;
	item_t         head;
	queue_status_t qstat;

	assign in_stall = qstat.is_full;
	assign push     = in_valid && !in_stall;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q    <= 6'd32;
			energy_scale_q <= 32'd16777216;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_SIDE:    grid_side_q    <= cfg_data[5:0];
				REG_ENERGY_SCALE: energy_scale_q <= cfg_data;
				default:          grid_side_q    <= grid_side_q;
			endcase
		end
	end

	grmv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.word     (in_word),
		.grid_side(grid_side_q),
		.item     (front_item)
	);

	grmv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(front_item),
		.pop      (pop),
		.head     (head),
		.status   (qstat)
	);

	grmv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.energy_scale(energy_scale_q),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.busy        (busy)
	);

	// Queue never overflows or underflows
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.is_full) && !(pop && !qstat.not_empty))
		else $error("queue overflow or underflow");

	// Energy is zero except on the last point
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.last_point |-> out_word.energy == '0)
		else $error("energy on a non-last point");

	// A pop starts the back end
	assert property (@(posedge clk) disable iff (!arst_n) pop |=> busy)
		else $error("back end did not start");

	// Back end never starts while a result waits
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !out_valid)
		else $error("start while output occupied");

endmodule
